FILE: sv/assert_macros.svh
// Assertion shorthands shared by the RTL. Each one clocks on clk and is
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/flr_pkg.sv
package flr_pkg;

	localparam int FRAC_BITS   = 10;
	localparam int SCREEN_SPAN = 1024;
	localparam int COORD_W     = 10;
	localparam int ACC_W       = 22;
	localparam int INC_W       = 12;
	localparam int COUNT_W     = 11;
	localparam int STRIDE_W    = 11;
	localparam int PIX_W       = 12;
	localparam int OFFSET_W    = 20;
	localparam int COLOR_W     = 8;

	// Dividend of the minor step is (|delta| + 1) << FRAC_BITS.
	localparam int NUM_W       = COUNT_W + FRAC_BITS;
	localparam int DIV_STEPS   = NUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1024);
	localparam logic [INC_W-1:0]    STEP_POS     = INC_W'(1 << FRAC_BITS);
	localparam logic [INC_W-1:0]    STEP_NEG     = INC_W'(-(1 << FRAC_BITS));

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} flr_state_t;

endpackage

FILE: sv/fixed_point_line_rasterizer.sv
// Fixed-point DDA line rasterizer with 10 fractional bits.
// Input channel (in_valid/in_stall) carries one item per beat: action 0 loads
// a line (endpoints and color), action 1 asks for the next pixel. Output
// channel (out_valid/out_stall) carries one pixel per beat: column, row,
// buffer offset row*line_stride+column, range flag, color and last mark.
// A load beat starts the divider: the minor-axis step is found by a
// restoring divider that retires one quotient bit per cycle through a
// single 12-bit subtract-and-compare unit, and in_stall stays high meanwhile.
// A step beat is answered by a pixel in the next cycle; steps may follow
// every cycle while out_stall is low. A step beat with no line active produces
// nothing. While the receiver holds out_stall the pending pixel stays put and
// in_stall is raised, so no further beat is taken until it drains. line_stride
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// idle, as the block itself does not enforce this. Reset (arst_n low) clears
// the line, out_valid and the divider control and sets line_stride to 1024.
`include "assert_macros.svh"

module fixed_point_line_rasterizer
	import flr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [STRIDE_W-1:0]        cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [COORD_W-1:0]         x_start,
	input  logic [COORD_W-1:0]         y_start,
	input  logic [COORD_W-1:0]         x_end,
	input  logic [COORD_W-1:0]         y_end,
	input  logic [COLOR_W-1:0]         color,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [PIX_W-1:0]    pixel_x,
	output logic signed [PIX_W-1:0]    pixel_y,
	output logic [OFFSET_W-1:0]        pixel_offset,
	output logic                       in_range,
	output logic [COLOR_W-1:0]         pixel_color,
	output logic                       last_pixel
);

	flr_state_t              state_q;
	logic [STRIDE_W-1:0]     stride_q;
	logic [ACC_W-1:0]        x_acc_q, y_acc_q;
	logic [INC_W-1:0]        x_inc_q, y_inc_q;
	logic [COUNT_W-1:0]      left_q;
	logic [COLOR_W-1:0]      color_q;

	logic [NUM_W-1:0]        div_num_q;
	logic [COUNT_W-1:0]      div_den_q;
	logic [COUNT_W-1:0]      div_rem_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic                    div_neg_q;
	logic                    div_minor_y_q;

	logic                    out_valid_q;
	logic [PIX_W-1:0]        px_q, py_q;
	logic [OFFSET_W-1:0]     offset_q;
	logic                    in_range_q;
	logic [COLOR_W-1:0]      pcolor_q;
	logic                    last_q;

	logic                    in_fire, out_fire, load_fire, step_fire;

	// Load decode.
	logic [COORD_W-1:0]      adx, ady, minor_mag;
	logic                    x_major, minor_neg;
	logic [COUNT_W-1:0]      load_count;

	// Shared divider unit.
	logic [COUNT_W:0]        trial;
	logic                    trial_ge;
	logic [COUNT_W-1:0]      rem_next;
	logic [INC_W-1:0]        quot_mag, quot_signed;
	logic                    div_last;

	// Pixel decode.
	logic [PIX_W-1:0]        px, py;
	logic                    coords_ok;
	logic [COORD_W+STRIDE_W-1:0] prod;
	logic [COORD_W+STRIDE_W:0]   offset_sum;
	logic                    offset_ok;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign load_fire = in_fire && (action == ACT_LOAD);
	assign step_fire = in_fire && (action == ACT_STEP) && (left_q != '0);

	always_comb begin
		adx        = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
		ady        = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
		x_major    = (adx >= ady);
		load_count = x_major ? COUNT_W'(adx) + COUNT_W'(1) : COUNT_W'(ady) + COUNT_W'(1);
		minor_mag  = x_major ? ady : adx;
		minor_neg  = x_major ? (y_end < y_start) : (x_end < x_start);
	end

	always_comb begin
		trial       = {div_rem_q, div_num_q[NUM_W-1]};
		trial_ge    = (trial >= {1'b0, div_den_q});
		rem_next    = trial_ge ? COUNT_W'(trial - {1'b0, div_den_q}) : trial[COUNT_W-1:0];
		div_last    = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		// The quotient never exceeds 1024, so it fits the increment width.
		quot_mag    = INC_W'({div_num_q[NUM_W-2:0], trial_ge});
		quot_signed = div_neg_q ? INC_W'(-quot_mag) : quot_mag;
	end

	always_comb begin
		px         = x_acc_q[ACC_W-1:FRAC_BITS];
		py         = y_acc_q[ACC_W-1:FRAC_BITS];
		coords_ok  = !px[PIX_W-1] && !py[PIX_W-1]
			&& (px < PIX_W'(SCREEN_SPAN)) && (py < PIX_W'(SCREEN_SPAN));
		prod       = (COORD_W+STRIDE_W)'(py[COORD_W-1:0]) * (COORD_W+STRIDE_W)'(stride_q);
		offset_sum = (COORD_W+STRIDE_W+1)'(prod) + (COORD_W+STRIDE_W+1)'(px[COORD_W-1:0]);
		offset_ok  = coords_ok && (offset_sum[COORD_W+STRIDE_W:OFFSET_W] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (cfg_wr_en) begin
			stride_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			x_acc_q   <= '0;
			y_acc_q   <= '0;
			x_inc_q   <= '0;
			y_inc_q   <= '0;
			left_q    <= '0;
			color_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						x_acc_q   <= {2'b00, x_start, FRAC_BITS'(0)};
						y_acc_q   <= {2'b00, y_start, FRAC_BITS'(0)};
						color_q   <= color;
						left_q    <= load_count;
						div_cnt_q <= '0;
						if (x_major) begin
							x_inc_q <= (x_start > x_end) ? STEP_NEG : STEP_POS;
						end else begin
							y_inc_q <= (y_start > y_end) ? STEP_NEG : STEP_POS;
						end
						state_q <= ST_DIV;
					end else if (step_fire) begin
						x_acc_q <= x_acc_q + {{(ACC_W-INC_W){x_inc_q[INC_W-1]}}, x_inc_q};
						y_acc_q <= y_acc_q + {{(ACC_W-INC_W){y_inc_q[INC_W-1]}}, y_inc_q};
						left_q  <= left_q - COUNT_W'(1);
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						if (div_minor_y_q) begin
							y_inc_q <= quot_signed;
						end else begin
							x_inc_q <= quot_signed;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath: the dividend register shifts out one bit a cycle and
	// fills from the bottom with quotient bits.
	always_ff @(posedge clk) begin
		if (load_fire) begin
			div_num_q     <= {COUNT_W'(minor_mag) + COUNT_W'(1), FRAC_BITS'(0)};
			div_den_q     <= load_count;
			div_rem_q     <= '0;
			div_neg_q     <= minor_neg;
			div_minor_y_q <= x_major;
		end else if (state_q == ST_DIV) begin
			div_num_q <= {div_num_q[NUM_W-2:0], trial_ge};
			div_rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			px_q       <= px;
			py_q       <= py;
			offset_q   <= offset_ok ? offset_sum[OFFSET_W-1:0] : '0;
			in_range_q <= offset_ok;
			pcolor_q   <= color_q;
			last_q     <= (left_q == COUNT_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign pixel_offset = offset_q;
	assign in_range     = in_range_q;
	assign pixel_color  = pcolor_q;
	assign last_pixel   = last_q;

	`ASSERT_SAME(a_stall_while_div, state_q == ST_DIV, in_stall,
		"input taken while the divider is busy")
	`ASSERT_NEXT(a_step_gives_pixel, step_fire, out_valid,
		"step on an active line produced no pixel")
	`ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && div_last, state_q == ST_IDLE,
		"divider ran past its last step")
	`ASSERT_SAME(a_offset_zero, out_valid && !in_range, pixel_offset == '0,
		"out-of-range pixel carries a nonzero offset")

endmodule
